### rtl/core/cbts_pkg.sv
// types, constants and the stub counting function of the corrected best-track selector
package cbts_pkg;

    localparam int TRACK_BITS   = 32;
    localparam int RANK_BITS    = 7;
    localparam int STUB_ID_BITS = 36;
    localparam int MODE_LSB     = 5;
    localparam int MODE_BITS    = 4;

    localparam int NUM_NEW     = 3;
    localparam int HIST_DEPTH  = 6;
    localparam int NUM_SLOTS   = 9;
    localparam int NUM_RESULTS = 3;
    localparam int STUB_FIELDS = 6;
    localparam int FIELD_BITS  = 6;
    localparam int CNT_BITS    = 3;
    localparam int PLACE_BITS  = 4;

    localparam int PRETRIG_BITS = 2;
    localparam int ACCEL_BITS   = 4;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PRETRIGGER = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACCEL_MODE = 1'b1;

    localparam logic [PRETRIG_BITS-1:0] PRETRIG_RESET = 2'd2;
    localparam logic [ACCEL_BITS-1:0]   ACCEL_RESET   = 4'd15;

    localparam logic [2:0] LATE2_DELAY = 3'd2;

    typedef struct packed {
        logic [RANK_BITS-1:0]    rank_a;
        logic [RANK_BITS-1:0]    rank_b;
        logic [RANK_BITS-1:0]    rank_c;
        logic [TRACK_BITS-1:0]   track_a;
        logic [TRACK_BITS-1:0]   track_b;
        logic [TRACK_BITS-1:0]   track_c;
        logic [STUB_ID_BITS-1:0] stubs_a;
        logic [STUB_ID_BITS-1:0] stubs_b;
        logic [STUB_ID_BITS-1:0] stubs_c;
        logic                    accel_found;
    } t_in_beat;

    typedef struct packed {
        logic [TRACK_BITS-1:0]   best_track;
        logic [TRACK_BITS-1:0]   second_track;
        logic [TRACK_BITS-1:0]   third_track;
        logic [STUB_ID_BITS-1:0] best_stubs;
        logic [STUB_ID_BITS-1:0] second_stubs;
        logic [STUB_ID_BITS-1:0] third_stubs;
    } t_out_beat;

    typedef struct packed {
        logic [CNT_BITS-1:0] late1;
        logic [CNT_BITS-1:0] late2;
    } t_counts;

    typedef struct packed {
        logic [RANK_BITS-1:0]    rank;
        logic [TRACK_BITS-1:0]   trk;
        logic [STUB_ID_BITS-1:0] stb;
        t_counts                 cnt;
    } t_slot;

    // late2: delay of two, late1: delay of one or more; empty stub numbers skipped
    function automatic t_counts count_stubs(input logic [STUB_ID_BITS-1:0] w);
        t_counts    c;
        logic [2:0] num;
        logic [2:0] dly;
        c = '0;
        for (int k = 0; k < STUB_FIELDS; k++) begin
            num = w[FIELD_BITS*k +: 3];
            dly = w[FIELD_BITS*k + 3 +: 3];
            if (num != 3'd0 && dly == LATE2_DELAY) begin
                c.late2 = c.late2 + 3'd1;
            end
            if (num != 3'd0 && dly != 3'd0) begin
                c.late1 = c.late1 + 3'd1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/bx_corrected_best_track_select.sv
// top level: bunch-crossing corrected best-track selector
// an input beat passes the input register, then the result register; one beat per cycle
// while i_stall is low; the nine-way rank compare sits between the two registers
// reset (synchronous, i_rst_n low): valids cleared, track history zeroed,
// pretrigger_stubs back to 2, accel_mode_code back to 15
module bx_corrected_best_track_select (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  cbts_pkg::t_in_beat                    i_in,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output cbts_pkg::t_out_beat                   o_out,
    input  logic                                  i_cfg_we,
    input  logic [cbts_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [cbts_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    // config registers
    logic [cbts_pkg::PRETRIG_BITS-1:0] r_pretrig;
    logic [cbts_pkg::ACCEL_BITS-1:0]   r_accel_code;

    // stage one: the current tick's tracks plus the two previous ticks
    cbts_pkg::t_slot r_cur  [cbts_pkg::NUM_NEW];
    cbts_pkg::t_slot r_hist [cbts_pkg::HIST_DEPTH];
    cbts_pkg::t_slot n_cur  [cbts_pkg::NUM_NEW];
    logic            r_accel;
    logic            r_s1_vld;

    // stage two: result register
    cbts_pkg::t_out_beat r_out;
    cbts_pkg::t_out_beat n_out;
    logic                r_out_vld;

    logic in_acc;
    logic s1_adv;

    // handshake: stage one moves on when the result register is empty or draining
    assign s1_adv  = r_s1_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_s1_vld && !s1_adv;
    assign in_acc  = i_valid && !o_stall;
    assign o_valid = r_out_vld;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pretrig    <= cbts_pkg::PRETRIG_RESET;
            r_accel_code <= cbts_pkg::ACCEL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cbts_pkg::CFG_PRETRIGGER: begin
                    r_pretrig <= i_cfg_data[cbts_pkg::PRETRIG_BITS-1:0];
                end
                cbts_pkg::CFG_ACCEL_MODE: begin
                    r_accel_code <= i_cfg_data[cbts_pkg::ACCEL_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pack the incoming tracks and count their late stubs
    always_comb begin
        n_cur[0].rank = i_in.rank_a;
        n_cur[1].rank = i_in.rank_b;
        n_cur[2].rank = i_in.rank_c;
        n_cur[0].trk  = i_in.track_a;
        n_cur[1].trk  = i_in.track_b;
        n_cur[2].trk  = i_in.track_c;
        n_cur[0].stb  = i_in.stubs_a;
        n_cur[1].stb  = i_in.stubs_b;
        n_cur[2].stb  = i_in.stubs_c;
        for (int k = 0; k < cbts_pkg::NUM_NEW; k++) begin
            n_cur[k].cnt = cbts_pkg::count_stubs(n_cur[k].stb);
        end
    end

    // the delay line shifts on every accepted beat, so history always
    // holds the two ticks before the one in r_cur
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cbts_pkg::NUM_NEW; k++) begin
                r_cur[k] <= '0;
            end
            for (int k = 0; k < cbts_pkg::HIST_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
            r_accel <= 1'b0;
        end else if (in_acc) begin
            for (int k = 0; k < cbts_pkg::NUM_NEW; k++) begin
                r_cur[k]                      <= n_cur[k];
                r_hist[k]                     <= r_cur[k];
                r_hist[cbts_pkg::NUM_NEW + k] <= r_hist[k];
            end
            r_accel <= i_in.accel_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    // selection: eligibility per slot, place by pairwise rank compare, then mux
    cbts_pkg::t_slot                   slot  [cbts_pkg::NUM_SLOTS];
    logic [cbts_pkg::NUM_SLOTS-1:0]    elig;
    logic [cbts_pkg::PLACE_BITS-1:0]   place [cbts_pkg::NUM_SLOTS];
    logic [cbts_pkg::TRACK_BITS-1:0]   res_trk [cbts_pkg::NUM_RESULTS];
    logic [cbts_pkg::STUB_ID_BITS-1:0] res_stb [cbts_pkg::NUM_RESULTS];
    logic [cbts_pkg::CNT_BITS-1:0]     pt;
    logic [cbts_pkg::TRACK_BITS-1:0]   mode_word;

    always_comb begin
        pt = cbts_pkg::CNT_BITS'(r_pretrig);
        for (int i = 0; i < cbts_pkg::NUM_NEW; i++) begin
            slot[i] = r_cur[i];
        end
        for (int i = 0; i < cbts_pkg::HIST_DEPTH; i++) begin
            slot[cbts_pkg::NUM_NEW + i] = r_hist[i];
        end

        // this tick: enough delay-two stubs; one back: late but not delay two;
        // two back: too few late stubs
        for (int i = 0; i < cbts_pkg::NUM_SLOTS; i++) begin
            if (i < cbts_pkg::NUM_NEW) begin
                elig[i] = (slot[i].rank != '0) && (slot[i].cnt.late2 >= pt);
            end else if (i < 2 * cbts_pkg::NUM_NEW) begin
                elig[i] = (slot[i].rank != '0) && (slot[i].cnt.late1 >= pt)
                          && (slot[i].cnt.late2 < pt);
            end else begin
                elig[i] = (slot[i].rank != '0) && (slot[i].cnt.late1 < pt);
            end
        end

        // ties go to the lower slot index
        for (int i = 0; i < cbts_pkg::NUM_SLOTS; i++) begin
            place[i] = '0;
            for (int j = 0; j < cbts_pkg::NUM_SLOTS; j++) begin
                if (j < i && elig[j] && slot[j].rank >= slot[i].rank) begin
                    place[i] = place[i] + 1'b1;
                end else if (j > i && elig[j] && slot[j].rank > slot[i].rank) begin
                    place[i] = place[i] + 1'b1;
                end
            end
        end

        // places are distinct among eligible slots, so an or-mux suffices
        for (int p = 0; p < cbts_pkg::NUM_RESULTS; p++) begin
            res_trk[p] = '0;
            res_stb[p] = '0;
            for (int i = 0; i < cbts_pkg::NUM_SLOTS; i++) begin
                if (elig[i] && place[i] == cbts_pkg::PLACE_BITS'(p)) begin
                    res_trk[p] = res_trk[p] | slot[i].trk;
                    res_stb[p] = res_stb[p] | slot[i].stb;
                end
            end
        end

        // accelerator code fills an empty third track word when accel_found was set
        mode_word = cbts_pkg::TRACK_BITS'(r_accel_code[cbts_pkg::MODE_BITS-1:0])
                    << cbts_pkg::MODE_LSB;

        n_out.best_track   = res_trk[0];
        n_out.second_track = res_trk[1];
        n_out.third_track  = (res_trk[2] == '0 && r_accel) ? mode_word : res_trk[2];
        n_out.best_stubs   = res_stb[0];
        n_out.second_stubs = res_stb[1];
        n_out.third_stubs  = res_stb[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || !i_stall) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

endmodule
